// ===== rtl/qats_pkg.sv =====
// shared types and constants for the quote aware token splitter
// no dependencies; used by the interfaces and all rtl modules
package qats_pkg;

  localparam int LENGTH_BITS    = 16;
  localparam int OFFSET_BITS    = 32;
  localparam int MASK_BITS      = 64;
  localparam int NUM_MASKS      = 4;
  localparam int CFG_INDEX_BITS = 2;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] QUOTE_BYTE     = 8'h22;
  localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // one result transaction
  typedef struct packed {
    logic [OFFSET_BITS-1:0] token_start;
    logic [LENGTH_BITS-1:0] token_length;
    logic                   length_saturated;
    logic                   final_token;
  } token_t;

  // results produced by one accepted byte, pushed into the output queue
  typedef struct packed {
    logic   push0;
    logic   push1;
    token_t tok0;
    token_t tok1;
  } push_t;

endpackage

// ===== rtl/qats_if.sv =====
// channel interfaces for the quote aware token splitter
// depends on qats_pkg
interface qats_in_if;
  import qats_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_text;

  modport source (output valid, output byte_in, output end_of_text, input ready);
  modport sink (input valid, input byte_in, input end_of_text, output ready);
endinterface

interface qats_out_if;
  import qats_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] token_start;
  logic [LENGTH_BITS-1:0] token_length;
  logic                   length_saturated;
  logic                   final_token;

  modport source (output valid, output token_start, output token_length,
                  output length_saturated, output final_token, input ready);
  modport sink (input valid, input token_start, input token_length,
                input length_saturated, input final_token, output ready);
endinterface

// ===== rtl/qats_core.sv =====
// delimiter masks, quote/escape tracking and token bookkeeping
// depends on qats_pkg; feeds qats_fifo through a qats_pkg::push_t
module qats_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [qats_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [qats_pkg::MASK_BITS-1:0]       cfg_data,
  input  logic                                 accept,
  input  logic [7:0]                           byte_in,
  input  logic                                 end_of_text,
  output qats_pkg::push_t                      push
);
  import qats_pkg::*;

  logic [MASK_BITS-1:0]   delim_mask [NUM_MASKS];
  logic                   inside_quotes, inside_quotes_next;
  logic                   escape_pending, escape_pending_next;
  logic [LENGTH_BITS-1:0] current_length, current_length_next;
  logic                   length_overflowed, length_overflowed_next;
  logic [OFFSET_BITS-1:0] current_start, current_start_next;
  logic [OFFSET_BITS-1:0] stream_position, stream_position_next;

  logic                   is_delim;
  logic                   split;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic                   q_upd, e_upd;
  logic [LENGTH_BITS-1:0] len_upd;
  logic                   ovf_upd;

  // delimiter mask registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MASKS; i++) delim_mask[i] <= '0;
    end else if (cfg_we) begin
      delim_mask[cfg_index] <= cfg_data;
    end
  end

  assign is_delim = delim_mask[byte_in[7:6]][byte_in[5:0]];
  assign split    = !inside_quotes && !escape_pending && is_delim;
  assign pos_inc  = stream_position + OFFSET_BITS'(1);

  // quote and escape update for a non-delimiter byte
  always_comb begin
    q_upd = inside_quotes;
    e_upd = escape_pending;
    if (escape_pending) begin
      e_upd = 1'b0;
    end else if (inside_quotes) begin
      if (byte_in == QUOTE_BYTE) q_upd = 1'b0;
    end else begin
      if (byte_in == QUOTE_BYTE) q_upd = 1'b1;
      if (byte_in == BACKSLASH_BYTE) e_upd = 1'b1;
    end
  end

  // saturating length count
  always_comb begin
    len_upd = current_length;
    ovf_upd = length_overflowed;
    if (current_length == LEN_MAX) begin
      ovf_upd = 1'b1;
    end else begin
      len_upd = current_length + LENGTH_BITS'(1);
    end
  end

  // results and next state for one byte
  always_comb begin
    inside_quotes_next     = inside_quotes;
    escape_pending_next    = escape_pending;
    current_length_next    = current_length;
    length_overflowed_next = length_overflowed;
    current_start_next     = current_start;
    stream_position_next   = stream_position;
    push                   = '0;
    if (accept) begin
      if (split) begin
        push.push0                  = 1'b1;
        push.tok0.token_start       = current_start;
        push.tok0.token_length      = current_length;
        push.tok0.length_saturated  = length_overflowed;
        push.tok0.final_token       = 1'b0;
        inside_quotes_next          = 1'b0;
        escape_pending_next         = 1'b0;
        current_length_next         = '0;
        length_overflowed_next      = 1'b0;
        if (end_of_text) begin
          // empty final token after a closing delimiter
          push.push1                  = 1'b1;
          push.tok1.token_start       = pos_inc;
          push.tok1.token_length      = '0;
          push.tok1.length_saturated  = 1'b0;
          push.tok1.final_token       = 1'b1;
          current_start_next          = '0;
          stream_position_next        = '0;
        end else begin
          current_start_next   = pos_inc;
          stream_position_next = pos_inc;
        end
      end else if (end_of_text) begin
        push.push0                  = 1'b1;
        push.tok0.token_start       = current_start;
        push.tok0.token_length      = len_upd;
        push.tok0.length_saturated  = ovf_upd;
        push.tok0.final_token       = 1'b1;
        inside_quotes_next          = 1'b0;
        escape_pending_next         = 1'b0;
        current_length_next         = '0;
        length_overflowed_next      = 1'b0;
        current_start_next          = '0;
        stream_position_next        = '0;
      end else begin
        inside_quotes_next     = q_upd;
        escape_pending_next    = e_upd;
        current_length_next    = len_upd;
        length_overflowed_next = ovf_upd;
        stream_position_next   = pos_inc;
      end
    end
  end

  // token state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_quotes     <= 1'b0;
      escape_pending    <= 1'b0;
      current_length    <= '0;
      length_overflowed <= 1'b0;
      current_start     <= '0;
      stream_position   <= '0;
    end else begin
      inside_quotes     <= inside_quotes_next;
      escape_pending    <= escape_pending_next;
      current_length    <= current_length_next;
      length_overflowed <= length_overflowed_next;
      current_start     <= current_start_next;
      stream_position   <= stream_position_next;
    end
  end

`ifndef ASSERT_OFF
  // the end of the stream returns offsets to zero
  assert property (@(posedge clk) disable iff (rst)
    accept && end_of_text |=> stream_position == '0 && current_start == '0)
    else $error("offsets not cleared after end of text");

  // quote and escape are never pending together
  assert property (@(posedge clk) disable iff (rst)
    !(inside_quotes && escape_pending))
    else $error("quote and escape both pending");
`endif

endmodule

// ===== rtl/qats_fifo.sv =====
// four entry output queue taking up to two tokens per cycle
// depends on qats_pkg
module qats_fifo (
  input  logic             clk,
  input  logic             rst,
  input  qats_pkg::push_t  push,
  output logic             room,
  input  logic             pop_ready,
  output logic             head_valid,
  output qats_pkg::token_t head
);
  import qats_pkg::*;

  token_t                   mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_BITS-1:0] count, count_next;
  logic                     pop;
  logic [1:0]               n_push;

  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign pop        = head_valid && pop_ready;
  assign room       = count <= FIFO_CNT_BITS'(FIFO_DEPTH - 2);
  assign n_push     = {1'b0, push.push0} + {1'b0, push.push1};
  assign count_next = count + FIFO_CNT_BITS'(n_push) - FIFO_CNT_BITS'(pop);

  // entry storage
  always_ff @(posedge clk) begin
    if (push.push0) mem[wr_ptr] <= push.tok0;
    if (push.push1) mem[wr_ptr + FIFO_PTR_BITS'(1)] <= push.tok1;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_BITS'(n_push);
      rd_ptr <= rd_ptr + FIFO_PTR_BITS'(pop);
      count  <= count_next;
    end
  end

`ifndef ASSERT_OFF
  // a second token only comes with a first
  assert property (@(posedge clk) disable iff (rst) push.push1 |-> push.push0)
    else $error("second token pushed without first");

  // pushes only while two slots are free
  assert property (@(posedge clk) disable iff (rst) push.push0 |-> room)
    else $error("push into full queue");

  // fill count stays within depth
  assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("queue count overflow");
`endif

endmodule

// ===== rtl/quote_aware_token_splitter.sv =====
// Splits a byte stream into tokens at configured delimiter bytes, honoring double quotes
// and backslash escapes, and reports each token's start offset and saturating length.
// One byte is accepted per cycle: the quote/escape and length update is a single pass of
// logic from the accepted byte into the state and a 4-entry output queue. A byte yields at
// most one token, except a delimiter on the end-of-text byte, which yields two; tokens
// leave the queue one per cycle while the sink is ready; input is held off while fewer
// than two queue slots are free. Depends on qats_pkg, qats_if, qats_core and qats_fifo.
module quote_aware_token_splitter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [qats_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [qats_pkg::MASK_BITS-1:0]      cfg_data,
  qats_in_if.sink                             in_ch,
  qats_out_if.source                          out_ch
);
  import qats_pkg::*;

  push_t  push;
  token_t head;
  logic   room;
  logic   head_valid;
  logic   accept;

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;

  // token logic
  qats_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .byte_in     (in_ch.byte_in),
    .end_of_text (in_ch.end_of_text),
    .push        (push)
  );

  // output queue
  qats_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .pop_ready  (out_ch.ready),
    .head_valid (head_valid),
    .head       (head)
  );

  // result channel
  assign out_ch.valid            = head_valid;
  assign out_ch.token_start      = head.token_start;
  assign out_ch.token_length     = head.token_length;
  assign out_ch.length_saturated = head.length_saturated;
  assign out_ch.final_token      = head.final_token;

endmodule

// ===== tb/tb.sv =====
// testbench for quote_aware_token_splitter: directed and random byte streams against a token predictor
// depends on qats_pkg, qats_in_if, qats_out_if and the quote_aware_token_splitter rtl
`timescale 1ns / 1ps

module tb;
  import qats_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int IDLE_PERCENT   = 18;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } text_item_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [MASK_BITS-1:0]      cfg_data;

  qats_in_if  in_ch ();
  qats_out_if out_ch ();

  quote_aware_token_splitter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // stimulus and expected token stores
  text_item_t byte_queue[$];
  token_t     expected_tokens[$];
  logic [7:0] delim_list[$];

  // predictor state
  logic [MASK_BITS-1:0]   delim_masks [NUM_MASKS];
  logic                   in_quotes;
  logic                   escape_pending;
  logic [LENGTH_BITS-1:0] tok_length;
  logic                   tok_overflow;
  logic [OFFSET_BITS-1:0] tok_start;
  logic [OFFSET_BITS-1:0] stream_pos;

  logic steady;
  int   mismatch_count;
  int   stall_cycles;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic token_t make_token(input logic [OFFSET_BITS-1:0] start,
                                        input logic [LENGTH_BITS-1:0] len,
                                        input logic sat, input logic fin);
    token_t t;
    t.token_start      = start;
    t.token_length     = len;
    t.length_saturated = sat;
    t.final_token      = fin;
    return t;
  endfunction

  task automatic clear_token(input logic [OFFSET_BITS-1:0] next_start);
    in_quotes      = 1'b0;
    escape_pending = 1'b0;
    tok_length     = '0;
    tok_overflow   = 1'b0;
    tok_start      = next_start;
  endtask

  // advance the splitter state by one byte and queue the tokens it closes
  task automatic split_byte(input logic [7:0] data, input logic last);
    logic [OFFSET_BITS-1:0] next_pos;
    logic                   is_delim;
    next_pos = stream_pos + 1'b1;
    is_delim = delim_masks[data[7:6]][data[5:0]];
    if (!in_quotes && !escape_pending && is_delim) begin
      expected_tokens.push_back(make_token(tok_start, tok_length, tok_overflow, 1'b0));
      clear_token(next_pos);
      if (last) begin
        // delimiter on the last byte closes with an empty final token
        expected_tokens.push_back(make_token(next_pos, '0, 1'b0, 1'b1));
        clear_token('0);
        stream_pos = '0;
      end else begin
        stream_pos = next_pos;
      end
    end else begin
      if (escape_pending) begin
        escape_pending = 1'b0;
      end else if (in_quotes) begin
        if (data == QUOTE_BYTE) in_quotes = 1'b0;
      end else begin
        if (data == QUOTE_BYTE) in_quotes = 1'b1;
        if (data == BACKSLASH_BYTE) escape_pending = 1'b1;
      end
      if (tok_length == LEN_MAX) tok_overflow = 1'b1;
      else tok_length = tok_length + 1'b1;
      if (last) begin
        expected_tokens.push_back(make_token(tok_start, tok_length, tok_overflow, 1'b1));
        clear_token('0);
        stream_pos = '0;
      end else begin
        stream_pos = next_pos;
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    text_item_t item;
    if (rst) begin
      in_ch.valid       <= 1'b0;
      in_ch.byte_in     <= '0;
      in_ch.end_of_text <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) split_byte(in_ch.byte_in, in_ch.end_of_text);
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_queue.size() > 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
          item = byte_queue.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.byte_in     <= item.data;
          in_ch.end_of_text <= item.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and checker
  always @(posedge clk) begin
    token_t exp_tok;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_tokens.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected token: start %0d len %0d sat %0b fin %0b",
                     out_ch.token_start, out_ch.token_length,
                     out_ch.length_saturated, out_ch.final_token);
        end else begin
          exp_tok = expected_tokens.pop_front();
          if (out_ch.token_start !== exp_tok.token_start ||
              out_ch.token_length !== exp_tok.token_length ||
              out_ch.length_saturated !== exp_tok.length_saturated ||
              out_ch.final_token !== exp_tok.final_token) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("token mismatch: expected start %0d len %0d sat %0b fin %0b",
                       exp_tok.token_start, exp_tok.token_length,
                       exp_tok.length_saturated, exp_tok.final_token);
              $display("                got start %0d len %0d sat %0b fin %0b",
                       out_ch.token_start, out_ch.token_length,
                       out_ch.length_saturated, out_ch.final_token);
            end
          end
        end
      end
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("quote_aware_token_splitter verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // write all four mask registers and rebuild the delimiter list
  task automatic load_masks(input logic [MASK_BITS-1:0] m0, input logic [MASK_BITS-1:0] m1,
                            input logic [MASK_BITS-1:0] m2, input logic [MASK_BITS-1:0] m3);
    logic [MASK_BITS-1:0] vals [NUM_MASKS];
    vals[0] = m0;
    vals[1] = m1;
    vals[2] = m2;
    vals[3] = m3;
    for (int i = 0; i < NUM_MASKS; i++) begin
      @(posedge clk);
      cfg_we         <= 1'b1;
      cfg_index      <= CFG_INDEX_BITS'(i);
      cfg_data       <= vals[i];
      delim_masks[i] = vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    delim_list.delete();
    for (int b = 0; b < 256; b++)
      if (delim_masks[b / 64][b % 64]) delim_list.push_back(8'(b));
  endtask

  function automatic logic [MASK_BITS-1:0] mask_of(input int k, input logic [7:0] vals[$]);
    logic [MASK_BITS-1:0] m;
    m = '0;
    foreach (vals[i])
      if (vals[i][7:6] == k) m[vals[i][5:0]] = 1'b1;
    return m;
  endfunction

  task automatic load_delims(input logic [7:0] vals[$]);
    load_masks(mask_of(0, vals), mask_of(1, vals), mask_of(2, vals), mask_of(3, vals));
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic last);
    text_item_t item;
    item.data = data;
    item.last = last;
    byte_queue.push_back(item);
  endtask

  function automatic logic [7:0] stream_byte();
    int r;
    r = $urandom_range(99);
    if (r < 30 && delim_list.size() > 0)
      return delim_list[$urandom_range(delim_list.size() - 1)];
    else if (r < 40) return QUOTE_BYTE;
    else if (r < 50) return BACKSLASH_BYTE;
    else return 8'($urandom_range(255));
  endfunction

  // one stream of random content, last byte flagged, often a delimiter
  task automatic queue_stream();
    int n;
    logic [7:0] tail;
    n = ($urandom_range(99) < 5) ? $urandom_range(25, 300) : $urandom_range(1, 24);
    for (int i = 1; i < n; i++) queue_byte(stream_byte(), 1'b0);
    tail = stream_byte();
    if ($urandom_range(99) < 30 && delim_list.size() > 0)
      tail = delim_list[$urandom_range(delim_list.size() - 1)];
    queue_byte(tail, 1'b1);
  endtask

  // wait for every byte to go in and every token to come out
  task automatic drain();
    while (byte_queue.size() > 0 || in_ch.valid || expected_tokens.size() > 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    logic [7:0] vals[$];
    int target;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_ch.valid       = 1'b0;
    in_ch.byte_in     = '0;
    in_ch.end_of_text = 1'b0;
    out_ch.ready   = 1'b0;
    steady         = 1'b0;
    mismatch_count = 0;
    stall_cycles   = 0;
    for (int i = 0; i < NUM_MASKS; i++) delim_masks[i] = '0;
    clear_token('0);
    stream_pos = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: comma plus the lowest and highest byte values as delimiters
    vals = '{8'h00, 8'h2C, 8'hFF};
    load_delims(vals);
    queue_byte("A", 1'b0);
    queue_byte(",", 1'b0);
    queue_byte(",", 1'b0);              // empty token
    queue_byte(QUOTE_BYTE, 1'b0);       // delimiter inside quotes is ordinary
    queue_byte("x", 1'b0);
    queue_byte(",", 1'b0);
    queue_byte(QUOTE_BYTE, 1'b0);
    queue_byte(BACKSLASH_BYTE, 1'b0);   // escaped delimiter stays in the token
    queue_byte(",", 1'b0);
    queue_byte(",", 1'b0);
    queue_byte(QUOTE_BYTE, 1'b0);       // backslash inside quotes has no effect
    queue_byte(BACKSLASH_BYTE, 1'b0);
    queue_byte(QUOTE_BYTE, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);            // delimiter on the last byte
    queue_byte("B", 1'b1);              // one-byte stream
    queue_byte(BACKSLASH_BYTE, 1'b0);   // escaped quote does not open
    queue_byte(QUOTE_BYTE, 1'b0);
    queue_byte(",", 1'b1);
    queue_byte(8'hFF, 1'b1);            // lone delimiter stream
    queue_byte(BACKSLASH_BYTE, 1'b1);   // backslash as last byte
    queue_byte(8'h80, 1'b1);
    drain();

    // random phases over several delimiter settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          vals = '{8'h2C, 8'h20, 8'h09};
          load_delims(vals);
        end
        1: load_masks('1, '1, '1, '1);
        2: load_masks('0, '0, '0, '0);
        3: begin
          load_masks({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
        end
        4: begin
          vals.delete();
          repeat ($urandom_range(1, 4)) vals.push_back(8'($urandom_range(255)));
          load_delims(vals);
        end
        default: begin
          vals = '{QUOTE_BYTE, BACKSLASH_BYTE, 8'h3B};
          load_delims(vals);
        end
      endcase
      steady = (phase == 3);
      target = byte_queue.size() + 290;
      while (byte_queue.size() < target) queue_stream();
      drain();
    end
    steady = 1'b0;

    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("quote_aware_token_splitter verification clean");
    end else begin
      $display("quote_aware_token_splitter verification failed");
    end
    $finish;
  end

endmodule
